FILE: sv/series_delta_and_rate_macros.svh
// Assertion macros for the series delta and rate checker.
`ifndef SERIES_DELTA_AND_RATE_MACROS_SVH
`define SERIES_DELTA_AND_RATE_MACROS_SVH

// Check cons in the same cycle as ante.
`define SDR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define SDR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/sdr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the series delta and rate block.
package sdr_pkg;

	typedef enum logic [1:0] {
		MODE_DIFF      = 2'd0,
		MODE_COUNTER   = 2'd1,
		MODE_RATE_MIN  = 2'd2,
		MODE_RATE_HOUR = 2'd3
	} mode_t;

	localparam int TS_BITS   = 64;
	localparam int MUL_CHUNK = 32;

	// ns per minute = KODD_MIN << KSH_MIN, ns per hour = KODD_HOUR << KSH_HOUR
	localparam int KODD_BITS = 29;
	localparam int KSH_MIN   = 11;
	localparam int KSH_HOUR  = 13;
	localparam logic [KODD_BITS-1:0] KODD_MIN  = 29'd29296875;
	localparam logic [KODD_BITS-1:0] KODD_HOUR = 29'd439453125;

	typedef struct packed {
		logic done;
		logic overflow;
	} div_status_t;

endpackage

FILE: sv/sdr_mul.sv
`timescale 1ns / 1ps
// Multi-cycle multiplier: magnitude times odd rate constant, one 32-bit chunk per cycle.
module sdr_mul import sdr_pkg::*; #(
	parameter int VALUE_BITS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [VALUE_BITS-1:0]           mag,
	input  logic [KODD_BITS-1:0]            kodd,
	output logic [VALUE_BITS+KODD_BITS-1:0] product,
	output logic                            done
);

	localparam int PROD_W = VALUE_BITS + KODD_BITS;
	localparam int CHUNKS = (VALUE_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int PAD_W  = CHUNKS * MUL_CHUNK;
	localparam int CNT_W  = $clog2(CHUNKS + 1);
	localparam int PART_W = MUL_CHUNK + KODD_BITS;

	logic [PAD_W-1:0]     mag_q;
	logic [KODD_BITS-1:0] kodd_q;
	logic [PROD_W-1:0]    acc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [PART_W-1:0]    partial;
	logic [PROD_W-1:0]    partial_sh;

	assign partial    = mag_q[MUL_CHUNK-1:0] * kodd_q;
	assign partial_sh = PROD_W'(partial) << (cnt_q * MUL_CHUNK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(CHUNKS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulate one partial product per cycle, lowest chunk first
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q  <= PAD_W'(mag);
			kodd_q <= kodd;
			acc_q  <= '0;
		end else if (busy_q) begin
			mag_q <= mag_q >> MUL_CHUNK;
			acc_q <= acc_q + partial_sh;
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

FILE: sv/sdr_div.sv
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle after a range check.
module sdr_div import sdr_pkg::*; #(
	parameter int VALUE_BITS = 48
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [VALUE_BITS+KODD_BITS+KSH_HOUR-1:0] numer,
	input  logic [TS_BITS-1:0]                       denom,
	output logic [VALUE_BITS-1:0]                    quot,
	output div_status_t                              status
);

	localparam int NUM_W = VALUE_BITS + KODD_BITS + KSH_HOUR;
	localparam int HI_W  = NUM_W - VALUE_BITS;
	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	typedef enum logic [1:0] {
		D_IDLE,
		D_CHECK,
		D_RUN
	} dstate_t;

	dstate_t              state_q;
	div_status_t          stat_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TS_BITS-1:0]   den_q;
	logic [HI_W-1:0]      hi_q;
	logic [VALUE_BITS-1:0] lo_q;
	logic [TS_BITS-1:0]   rem_q;
	logic [TS_BITS:0]     trial;
	logic [TS_BITS:0]     trial_sub;
	logic                 fits;
	logic                 too_big;

	assign trial     = {rem_q, lo_q[VALUE_BITS-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign fits      = trial >= {1'b0, den_q};
	// quotient reaches 2^VALUE_BITS when the upper numerator part is not below the divisor
	assign too_big   = TS_BITS'(hi_q) >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			stat_q  <= '0;
			cnt_q   <= '0;
		end else begin
			stat_q <= '0;
			case (state_q)
				D_IDLE: begin
					if (start) state_q <= D_CHECK;
				end
				D_CHECK: begin
					if (too_big) begin
						stat_q  <= '{done: 1'b1, overflow: 1'b1};
						state_q <= D_IDLE;
					end else begin
						cnt_q   <= CNT_W'(VALUE_BITS);
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						stat_q  <= '{done: 1'b1, overflow: 1'b0};
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// shift numerator bits out of lo_q and quotient bits in behind them
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= denom;
			hi_q  <= numer[NUM_W-1 -: HI_W];
			lo_q  <= numer[VALUE_BITS-1:0];
		end else if (state_q == D_CHECK) begin
			rem_q <= TS_BITS'(hi_q);
		end else if (state_q == D_RUN) begin
			rem_q <= fits ? trial_sub[TS_BITS-1:0] : trial[TS_BITS-1:0];
			lo_q  <= {lo_q[VALUE_BITS-2:0], fits};
		end
	end

	assign quot   = lo_q;
	assign status = stat_q;

endmodule

FILE: sv/series_delta_and_rate.sv
`timescale 1ns / 1ps
// Top level: per-point difference, counter difference and rate of a time series.
//
//   channel  | handshake          | words
//   ---------+--------------------+------------------------------------------------------
//   in       | in_valid/in_ready  | timestamp_ns, sample_value, sample_present, series_start
//   out      | out_valid/out_ready| result_value, result_present, saturated
//   cfg      | cfg_we (no wait)   | cfg_wdata = transform_mode
//
// Null or zero results pass from the difference state to the final state, difference modes also
// pass the magnitude state, rate modes then a multiply over 32-bit chunks and one quotient bit
// per cycle, the quotient bits skipped when the range check finds an overflow.
// in_ready returns as the output register loads.
// Reset clears control state and the prior point; no clearing pass.
// A waiting result does not block the next word; the one after it holds in the final state.
module series_delta_and_rate import sdr_pkg::*; #(
	parameter int VALUE_BITS = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [TS_BITS-1:0]           timestamp_ns,
	input  logic signed [VALUE_BITS-1:0] sample_value,
	input  logic                         sample_present,
	input  logic                         series_start,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [VALUE_BITS-1:0] result_value,
	output logic                         result_present,
	output logic                         saturated,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_wdata
);

	localparam int NUM_W  = VALUE_BITS + KODD_BITS + KSH_HOUR;
	localparam int PROD_W = VALUE_BITS + KODD_BITS;
	localparam logic [VALUE_BITS-1:0] MIN_MAG = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] MAX_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_ABS,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		K_NULL,
		K_ZERO,
		K_ARITH
	} kind_t;

	state_t                 state_q;
	mode_t                  mode_q;
	kind_t                  kind_q;
	logic [VALUE_BITS-1:0]  cur_q;
	logic [TS_BITS-1:0]     ts_q;
	logic                   pres_q;
	logic                   start_q;
	logic [VALUE_BITS-1:0]  prior_val_q;
	logic [TS_BITS-1:0]     prior_ts_q;
	logic                   prior_pres_q;
	logic                   have_prior_q;
	logic [VALUE_BITS:0]    diff_q;
	logic [TS_BITS-1:0]     gap_q;
	logic                   neg_q;
	logic [VALUE_BITS-1:0]  mag_q;
	logic                   ovf_q;
	logic                   mul_go_q;
	logic                   div_go_q;
	logic                   out_valid_q;
	logic [VALUE_BITS-1:0]  out_val_q;
	logic                   out_pres_q;
	logic                   out_sat_q;

	logic                   is_rate;
	logic [KODD_BITS-1:0]   kodd;
	logic [PROD_W-1:0]      product;
	logic                   mul_done;
	logic [NUM_W-1:0]       numer;
	logic [VALUE_BITS-1:0]  quot;
	div_status_t            div_stat;

	logic [VALUE_BITS-1:0]  clip_mag;
	logic [VALUE_BITS-1:0]  limit;
	logic [VALUE_BITS-1:0]  clip_sel;
	logic                   over;
	logic [VALUE_BITS-1:0]  fin_val;
	logic                   fin_pres;
	logic                   fin_sat;

	assign is_rate = mode_q inside {MODE_RATE_MIN, MODE_RATE_HOUR};
	assign kodd    = (mode_q == MODE_RATE_HOUR) ? KODD_HOUR : KODD_MIN;
	assign numer   = (mode_q == MODE_RATE_HOUR) ? (NUM_W'(product) << KSH_HOUR)
		: (NUM_W'(product) << KSH_MIN);

	sdr_mul #(.VALUE_BITS(VALUE_BITS)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_go_q),
		.mag     (mag_q),
		.kodd    (kodd),
		.product (product),
		.done    (mul_done)
	);

	sdr_div #(.VALUE_BITS(VALUE_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.numer  (numer),
		.denom  (gap_q),
		.quot   (quot),
		.status (div_stat)
	);

	// clip to the signed range and apply sign
	always_comb begin
		clip_mag = is_rate ? quot : mag_q;
		limit    = neg_q ? MIN_MAG : MAX_POS;
		over     = (is_rate && ovf_q) || (clip_mag > limit);
		clip_sel = over ? limit : clip_mag;
		fin_val  = neg_q ? (VALUE_BITS'(0) - clip_sel) : clip_sel;
		fin_sat  = over;
		fin_pres = 1'b1;
		case (kind_q)
			K_ARITH: begin
				// counter reset: a drop yields the current value
				if (mode_q == MODE_COUNTER && neg_q) begin
					fin_val = cur_q;
					fin_sat = 1'b0;
				end
			end
			K_ZERO: begin
				fin_val = '0;
				fin_sat = 1'b0;
			end
			default: begin
				fin_val  = '0;
				fin_sat  = 1'b0;
				fin_pres = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= MODE_DIFF;
			kind_q       <= K_NULL;
			cur_q        <= '0;
			ts_q         <= '0;
			pres_q       <= 1'b0;
			start_q      <= 1'b0;
			prior_val_q  <= '0;
			prior_ts_q   <= '0;
			prior_pres_q <= 1'b0;
			have_prior_q <= 1'b0;
			diff_q       <= '0;
			gap_q        <= '0;
			neg_q        <= 1'b0;
			mag_q        <= '0;
			ovf_q        <= 1'b0;
			mul_go_q     <= 1'b0;
			div_go_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_val_q    <= '0;
			out_pres_q   <= 1'b0;
			out_sat_q    <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (cfg_we) mode_q <= mode_t'(cfg_wdata);
			// drop the taken word unless the final state reloads the register
			if (out_valid_q && out_ready && state_q != ST_FIN) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cur_q   <= sample_value;
						ts_q    <= timestamp_ns;
						pres_q  <= sample_present;
						start_q <= series_start;
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					diff_q <= {cur_q[VALUE_BITS-1], cur_q}
						- {prior_val_q[VALUE_BITS-1], prior_val_q};
					gap_q  <= ts_q - prior_ts_q;
					if (start_q || !have_prior_q) begin
						kind_q  <= K_NULL;
						state_q <= ST_FIN;
					end else if (is_rate && ts_q <= prior_ts_q) begin
						kind_q  <= K_ZERO;
						state_q <= ST_FIN;
					end else if (!(pres_q && prior_pres_q)) begin
						kind_q  <= K_NULL;
						state_q <= ST_FIN;
					end else begin
						kind_q  <= K_ARITH;
						state_q <= ST_ABS;
					end
					// every point becomes the prior point, null or not
					prior_val_q  <= cur_q;
					prior_ts_q   <= ts_q;
					prior_pres_q <= pres_q;
					have_prior_q <= 1'b1;
				end
				ST_ABS: begin
					neg_q <= diff_q[VALUE_BITS];
					mag_q <= diff_q[VALUE_BITS] ? VALUE_BITS'(~diff_q + (VALUE_BITS+1)'(1))
						: diff_q[VALUE_BITS-1:0];
					if (is_rate) begin
						mul_go_q <= 1'b1;
						state_q  <= ST_MUL;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						ovf_q   <= div_stat.overflow;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_val_q   <= fin_val;
						out_pres_q  <= fin_pres;
						out_sat_q   <= fin_sat;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready       = (state_q == ST_IDLE);
	assign out_valid      = out_valid_q;
	assign result_value   = out_val_q;
	assign result_present = out_pres_q;
	assign saturated      = out_sat_q;

endmodule

FILE: sv/sdr_check.sv
`timescale 1ns / 1ps
// Port-level checker for series_delta_and_rate, bound to the top level.
`include "series_delta_and_rate_macros.svh"
module sdr_check #(
	parameter int VALUE_BITS = 48
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [VALUE_BITS-1:0] result_value,
	input logic                         result_present,
	input logic                         saturated
);

	localparam logic [VALUE_BITS-1:0] MIN_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] MAX_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};

	`SDR_ASSERT_NEXT(a_one_word_at_a_time, in_valid && in_ready, !in_ready, "input taken while busy")
	`SDR_ASSERT_NOW(a_null_is_clear, out_valid && !result_present, result_value == '0 && !saturated, "null result carries data")
	`SDR_ASSERT_NOW(a_sat_at_limit, out_valid && saturated, result_value == MAX_POS || result_value == MIN_NEG, "saturated value off the range limit")
	`SDR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(result_present) && $stable(saturated), "stalled result changed")

endmodule

bind series_delta_and_rate sdr_check #(.VALUE_BITS(VALUE_BITS)) u_sdr_check (.*);
